// File: rtl/kmp_pkg.sv
// Shared constants, types and codes of the streaming KMP matcher.
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int LINK_W      = LEN_W + 1;
  localparam int IDX_W       = $clog2(MAX_PATTERN);

  localparam int CMD_DEPTH   = 4;
  localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

  localparam int OUT_DEPTH   = 2;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam int POS_W       = 32;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  typedef logic signed [LINK_W-1:0] link_t;

  localparam link_t LINK_NONE = '1;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_TEXT
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_MATCH
  } st_e;

endpackage

`default_nettype wire

// File: rtl/kmp_front.sv
// Front end: accepts items, decodes the op and queues commands for the engine.
`timescale 1ns / 1ps
`default_nettype none

module kmp_front import kmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] op_i,
  input  logic [7:0] data_byte_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  cmd_t                 queue_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wptr_q, wptr_d;
  logic [CMD_PTR_W-1:0] rptr_q, rptr_d;
  logic [CMD_CNT_W-1:0] cnt_q, cnt_d;

  cmd_t cmd_in;
  logic keep;
  logic wr_en;
  logic rd_en;

  always_comb begin
    cmd_in.data = data_byte_i;
    cmd_in.kind = CMD_CLEAR;
    keep        = 1'b1;
    unique case (op_i)
      OP_CLEAR:  cmd_in.kind = CMD_CLEAR;
      OP_APPEND: cmd_in.kind = CMD_APPEND;
      OP_TEXT:   cmd_in.kind = CMD_TEXT;
      OP_NOP:    keep = 1'b0;
    endcase
  end

  assign full        = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rptr_q];
  assign wr_en       = push && !full && keep;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_en) begin
      wptr_d = (wptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wptr_q + CMD_PTR_W'(1);
    end
    if (rd_en) begin
      rptr_d = (rptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rptr_q + CMD_PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CMD_CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_q[wptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/kmp_back.sv
// Back end: pattern store, failure table and the link-walking match engine.
`timescale 1ns / 1ps
`default_nettype none

module kmp_back import kmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [POS_W-1:0] res_o
);

  logic [7:0] store_mem [MAX_PATTERN];
  link_t      ft_mem    [MAX_PATTERN];

  st_e              state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  link_t            bprog_q, bprog_d;
  logic [LEN_W-1:0] mprog_q, mprog_d;
  logic [POS_W-1:0] pos_q, pos_d;
  link_t            j_q, j_d;
  logic [7:0]       byte_q, byte_d;
  logic             app_q, app_d;

  link_t            rd_j;
  logic [LEN_W-1:0] rd_pos;
  logic [LEN_W-1:0] ft_idx;
  logic             rd_ok;
  logic [7:0]       store_rd;
  link_t            ft_rd;
  logic [7:0]       cur_byte;
  logic             hit;
  logic [LEN_W-1:0] jn;
  logic [LEN_W-1:0] len_m1;

  logic             st_we;
  logic [IDX_W-1:0] st_widx;
  logic [7:0]       st_wdata;
  logic             ft_we;
  logic [IDX_W-1:0] ft_widx;
  link_t            ft_wdata;

  always_comb begin
    rd_j = bprog_q;
    unique case (state_q)
      ST_IDLE:  rd_j = bprog_q;
      ST_WALK:  rd_j = j_q;
      ST_MATCH: rd_j = link_t'({1'b0, len_q});
      default:  rd_j = bprog_q;
    endcase
  end

  assign rd_pos   = rd_j[LEN_W-1:0];
  assign rd_ok    = !rd_j[LINK_W-1] && (rd_pos < len_q);
  assign store_rd = store_mem[rd_pos[IDX_W-1:0]];
  assign ft_idx   = rd_pos - LEN_W'(1);
  assign ft_rd    = (rd_pos == '0) ? LINK_NONE : ft_mem[ft_idx[IDX_W-1:0]];
  assign cur_byte = (state_q == ST_IDLE) ? cmd_i.data : byte_q;
  assign hit      = (store_rd == cur_byte);
  assign jn       = rd_ok ? rd_pos + LEN_W'(1) : '0;
  assign len_m1   = len_q - LEN_W'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == CMD_APPEND && len_q < LEN_W'(MAX_PATTERN)) begin
            state_d = ST_WALK;
          end else if (cmd_i.kind == CMD_TEXT && len_q != '0) begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (!(rd_ok && !hit)) begin
          state_d = (!app_q && jn >= len_q) ? ST_MATCH : ST_IDLE;
        end
      end
      ST_MATCH: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    len_d       = len_q;
    bprog_d     = bprog_q;
    mprog_d     = mprog_q;
    pos_d       = pos_q;
    j_d         = j_q;
    byte_d      = byte_q;
    app_d       = app_q;
    cmd_pop_o   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = pos_q - POS_W'(len_q);
    st_we       = 1'b0;
    st_widx     = len_q[IDX_W-1:0];
    st_wdata    = cmd_i.data;
    ft_we       = 1'b0;
    ft_widx     = len_m1[IDX_W-1:0];
    ft_wdata    = bprog_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_CLEAR: begin
              len_d   = '0;
              bprog_d = LINK_NONE;
              mprog_d = '0;
              pos_d   = '0;
            end
            CMD_APPEND: begin
              if (len_q < LEN_W'(MAX_PATTERN)) begin
                st_we = 1'b1;
                if (len_q != '0) begin
                  ft_we    = 1'b1;
                  ft_wdata = (rd_ok && hit) ? ft_rd : bprog_q;
                end
                j_d    = bprog_q;
                byte_d = cmd_i.data;
                app_d  = 1'b1;
              end
            end
            CMD_TEXT: begin
              if (len_q == '0) begin
                pos_d = pos_q + POS_W'(1);
              end else begin
                j_d    = link_t'({1'b0, mprog_q});
                byte_d = cmd_i.data;
                app_d  = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (rd_ok && !hit) begin
          j_d = ft_rd;
        end else if (app_q) begin
          ft_we    = 1'b1;
          ft_widx  = len_q[IDX_W-1:0];
          ft_wdata = link_t'({1'b0, jn});
          bprog_d  = link_t'({1'b0, jn});
          len_d    = len_q + LEN_W'(1);
        end else begin
          pos_d = pos_q + POS_W'(1);
          if (jn < len_q) begin
            mprog_d = jn;
          end
        end
      end
      ST_MATCH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          mprog_d = ft_rd[LINK_W-1] ? '0 : ft_rd[LEN_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      bprog_q <= LINK_NONE;
      mprog_q <= '0;
      pos_q   <= '0;
      app_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      bprog_q <= bprog_d;
      mprog_q <= mprog_d;
      pos_q   <= pos_d;
      app_q   <= app_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    byte_q <= byte_d;
    if (st_we) begin
      store_mem[st_widx] <= st_wdata;
    end
    if (ft_we) begin
      ft_mem[ft_widx] <= ft_wdata;
    end
  end

endmodule

`default_nettype wire

// File: rtl/kmp_out.sv
// Result queue: holds match start indices until they are popped.
`timescale 1ns / 1ps
`default_nettype none

module kmp_out import kmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  output logic             res_ready_o,
  input  logic [POS_W-1:0] res_i,
  output logic             empty,
  input  logic             pop,
  output logic [POS_W-1:0] match_start_o
);

  logic [POS_W-1:0]     queue_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wptr_q, wptr_d;
  logic [OUT_PTR_W-1:0] rptr_q, rptr_d;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 wr_en;
  logic                 rd_en;

  assign res_ready_o   = (cnt_q != OUT_CNT_W'(OUT_DEPTH));
  assign empty         = (cnt_q == '0);
  assign match_start_o = queue_q[rptr_q];
  assign wr_en         = res_valid_i && res_ready_o;
  assign rd_en         = pop && !empty;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_en) begin
      wptr_d = (wptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wptr_q + OUT_PTR_W'(1);
    end
    if (rd_en) begin
      rptr_d = (rptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rptr_q + OUT_PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + OUT_CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_q[wptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/kmp_stream_matcher.sv
// Top level of the streaming KMP matcher: front queue, match engine, result queue.
//
//   channel  | handshake        | payload
//   ---------+------------------+----------------------------
//   input    | push / full      | op_i[1:0], data_byte_i[7:0]
//   result   | empty / pop      | match_start_o[31:0]
//
// The front drops a no-operation item at once; other items are queued for the engine.
// A clear, an append to a full pattern or a text byte with no pattern is done while idle.
// An append or a text byte goes on to the walk state, which takes one failure link per step,
// and a byte that ends a match enters the match state until the result queue has room.
// A four-entry command queue absorbs long link chains and a two-entry result queue lets
// matching go on while results wait. Reset empties the pattern and both queues at once.
`timescale 1ns / 1ps
`default_nettype none

module kmp_stream_matcher import kmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] match_start_o
);

  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic             res_valid;
  logic             res_ready;
  logic [POS_W-1:0] res;

  kmp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  kmp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  kmp_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_ready_o   (res_ready),
    .res_i         (res),
    .empty         (empty),
    .pop           (pop),
    .match_start_o (match_start_o)
  );

endmodule

`default_nettype wire
